// ===== rtl/wmhp_pkg.sv =====
`timescale 1ns / 1ps
// wmhp_pkg: shared constants, frame-state and result types, element start lookup
// for the 802.11 MAC header parser. No dependencies.
package wmhp_pkg;

   localparam int MAX_FRAME_LEN = 4096;
   localparam int CNT_W         = $clog2(MAX_FRAME_LEN + 1);
   localparam logic [CNT_W-1:0] POS_NONE = {CNT_W{1'b1}};

   localparam logic [1:0] TYPE_MGMT    = 2'd0;
   localparam logic [1:0] TYPE_CTRL    = 2'd1;
   localparam logic [1:0] TYPE_DATA    = 2'd2;
   localparam logic [1:0] TYPE_UNKNOWN = 2'd3;

   localparam logic [5:0] SUB_UNKNOWN = 6'd63;
   localparam logic [5:0] SUB_EXT_BASE = 6'd16;

   localparam logic [3:0] MGT_ASSOC_REQ   = 4'd0;
   localparam logic [3:0] MGT_REASSOC_REQ = 4'd2;
   localparam logic [3:0] MGT_PROBE_REQ   = 4'd4;
   localparam logic [3:0] MGT_PROBE_RSP   = 4'd5;
   localparam logic [3:0] MGT_RSVD_A      = 4'd7;
   localparam logic [3:0] MGT_BEACON      = 4'd8;
   localparam logic [3:0] MGT_RSVD_B      = 4'd15;

   localparam logic [3:0] CTL_BFRP        = 4'd4;
   localparam logic [3:0] CTL_VHT_NDPA    = 4'd5;
   localparam logic [3:0] CTL_EXTENSION   = 4'd6;
   localparam logic [3:0] CTL_WRAPPER     = 4'd7;
   localparam logic [3:0] CTL_BAR         = 4'd8;
   localparam logic [3:0] CTL_BA          = 4'd9;
   localparam logic [3:0] CTL_PSPOLL      = 4'd10;
   localparam logic [3:0] CTL_RTS         = 4'd11;
   localparam logic [3:0] CTL_CFEND       = 4'd14;
   localparam logic [3:0] CTL_CFEND_ACK   = 4'd15;
   localparam logic [3:0] EXT_MIN         = 4'd2;
   localparam logic [3:0] EXT_MAX         = 4'd10;

   localparam logic [3:0] DATA_RSVD       = 4'd13;
   localparam logic [3:0] DATA_QOS_FIRST  = 4'd8;

   localparam logic [2:0] SLOT_NONE = 3'd0;
   localparam logic [2:0] SLOT_1    = 3'd1;
   localparam logic [2:0] SLOT_2    = 3'd2;
   localparam logic [2:0] SLOT_3    = 3'd3;
   localparam logic [2:0] SLOT_4    = 3'd4;

   localparam logic [CNT_W-1:0] POS_QOS_SHORT = CNT_W'(25);
   localparam logic [CNT_W-1:0] POS_QOS_LONG  = CNT_W'(31);

   typedef struct packed {
      logic [CNT_W-1:0] byte_count;
      logic [15:0]      fc_word;
      logic [7:0]       qos_short;
      logic [7:0]       qos_long;
      logic [CNT_W-1:0] next_tag_pos;
      logic [CNT_W-1:0] ssid_pos;
      logic [7:0]       ssid_len;
      logic             tag_id_zero;
      logic             ssid_found;
   } frame_state_type;

   typedef struct packed {
      logic [1:0]  frame_type;
      logic [5:0]  subtype_code;
      logic [7:0]  fc_flags;
      logic        amsdu_present;
      logic [2:0]  ra_slot;
      logic [2:0]  ta_slot;
      logic [2:0]  bssid_slot;
      logic [2:0]  da_slot;
      logic [2:0]  sa_slot;
      logic [11:0] ssid_offset;
      logic [7:0]  ssid_length;
   } result_type;

   // offset of the first information element, 0 for frames without an SSID
   function automatic logic [CNT_W-1:0] ie_start(input logic [1:0] ftype,
                                                 input logic [3:0] nib);
      logic [CNT_W-1:0] st;
      st = '0;
      if (ftype == TYPE_MGMT) begin
         unique case (nib)
            MGT_BEACON, MGT_PROBE_RSP: st = CNT_W'(36);
            MGT_PROBE_REQ:             st = CNT_W'(24);
            MGT_ASSOC_REQ:             st = CNT_W'(28);
            MGT_REASSOC_REQ:           st = CNT_W'(34);
            default:                   st = '0;
         endcase
      end
      return st;
   endfunction

endpackage

// ===== rtl/wmhp_ifs.sv =====
`timescale 1ns / 1ps
// wmhp_req_if / wmhp_rsp_if: valid/ready channels for frame bytes and parse results.
// Depends on nothing.
interface wmhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, frame_byte, last_byte, input ready);
   modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface wmhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  frame_type;
   logic [5:0]  subtype_code;
   logic [7:0]  fc_flags;
   logic        amsdu_present;
   logic [2:0]  ra_slot;
   logic [2:0]  ta_slot;
   logic [2:0]  bssid_slot;
   logic [2:0]  da_slot;
   logic [2:0]  sa_slot;
   logic [11:0] ssid_offset;
   logic [7:0]  ssid_length;

   modport source (output valid, frame_type, subtype_code, fc_flags, amsdu_present,
                   ra_slot, ta_slot, bssid_slot, da_slot, sa_slot, ssid_offset,
                   ssid_length, input ready);
   modport sink   (input valid, frame_type, subtype_code, fc_flags, amsdu_present,
                   ra_slot, ta_slot, bssid_slot, da_slot, sa_slot, ssid_offset,
                   ssid_length, output ready);
endinterface

// ===== rtl/wmhp_byte_track.sv =====
`timescale 1ns / 1ps
// wmhp_byte_track: per-frame state (byte count, frame control, QoS bytes, IE walk).
// Depends on wmhp_pkg.
module wmhp_byte_track (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                frame_byte,
   input  logic                      last_byte,
   output wmhp_pkg::frame_state_type state_upd
);

   wmhp_pkg::frame_state_type state_ff, state_in, upd;
   logic [wmhp_pkg::CNT_W-1:0] pos;
   logic [wmhp_pkg::CNT_W-1:0] st;
   logic [wmhp_pkg::CNT_W:0]   tag_ext;
   logic [wmhp_pkg::CNT_W:0]   walk_sum;

   always_comb begin
      upd      = state_ff;
      pos      = state_ff.byte_count;
      st       = wmhp_pkg::ie_start(frame_byte[3:2], frame_byte[7:4]);
      tag_ext  = '0;
      walk_sum = '0;
      if (state_ff.byte_count < wmhp_pkg::CNT_W'(wmhp_pkg::MAX_FRAME_LEN)) begin
         if (pos == '0) begin
            upd.fc_word      = {frame_byte, 8'h00};
            upd.next_tag_pos = (st != '0) ? st : wmhp_pkg::POS_NONE;
            upd.tag_id_zero  = 1'b0;
            upd.ssid_found   = 1'b0;
         end else if (pos == wmhp_pkg::CNT_W'(1)) begin
            upd.fc_word[7:0] = frame_byte;
         end
         if (pos == wmhp_pkg::POS_QOS_SHORT) upd.qos_short = frame_byte;
         if (pos == wmhp_pkg::POS_QOS_LONG)  upd.qos_long  = frame_byte;

         tag_ext  = {1'b0, upd.next_tag_pos};
         walk_sum = tag_ext + (wmhp_pkg::CNT_W+1)'(frame_byte) + (wmhp_pkg::CNT_W+1)'(2);
         if (!upd.ssid_found) begin
            if ({1'b0, pos} == tag_ext) begin
               upd.tag_id_zero = (frame_byte == 8'h00);
            end else if ({1'b0, pos} == tag_ext + (wmhp_pkg::CNT_W+1)'(1)) begin
               if (upd.tag_id_zero) begin
                  upd.tag_id_zero = 1'b0;
                  upd.ssid_found  = 1'b1;
                  upd.ssid_pos    = pos + wmhp_pkg::CNT_W'(1);
                  upd.ssid_len    = frame_byte;
               end else begin
                  upd.next_tag_pos = (walk_sum > {1'b0, wmhp_pkg::POS_NONE}) ?
                                     wmhp_pkg::POS_NONE : walk_sum[wmhp_pkg::CNT_W-1:0];
               end
            end
         end else if (pos == upd.ssid_pos && frame_byte == 8'h00) begin
            upd.ssid_len = 8'h00;
         end
         upd.byte_count = pos + wmhp_pkg::CNT_W'(1);
      end
      state_upd = upd;
      if (step) begin
         state_in = last_byte ? '0 : upd;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/wmhp_decode.sv =====
`timescale 1ns / 1ps
// wmhp_decode: builds the result (type, subtype, flags, address slots, SSID)
// from the frame state after the last byte. Depends on wmhp_pkg.
module wmhp_decode (
   input  wmhp_pkg::frame_state_type fs,
   output wmhp_pkg::result_type      res
);

   logic [wmhp_pkg::CNT_W-1:0] sz;
   logic [7:0] b0, b1, flags, q;
   logic [1:0] t;
   logic [3:0] nib, ext;
   logic [5:0] code;
   logic       is_ext, to_ds, from_ds, amsdu;
   logic [2:0] a1, a2, a3, a4, ra, bssid, da, sa;
   logic [wmhp_pkg::CNT_W-1:0] st;
   logic       ctl_a2;

   always_comb begin
      sz  = fs.byte_count;
      b0  = fs.fc_word[15:8];
      b1  = fs.fc_word[7:0];
      t   = b0[3:2];
      nib = b0[7:4];
      ext = b1[3:0];

      unique case (t)
         wmhp_pkg::TYPE_MGMT:
            code = (nib == wmhp_pkg::MGT_RSVD_A || nib == wmhp_pkg::MGT_RSVD_B) ?
                   wmhp_pkg::SUB_UNKNOWN : {2'b00, nib};
         wmhp_pkg::TYPE_DATA:
            code = (nib == wmhp_pkg::DATA_RSVD) ? wmhp_pkg::SUB_UNKNOWN : {2'b00, nib};
         wmhp_pkg::TYPE_CTRL: begin
            if (nib == wmhp_pkg::CTL_BFRP || nib == wmhp_pkg::CTL_VHT_NDPA ||
                nib >= wmhp_pkg::CTL_WRAPPER) begin
               code = {2'b00, nib};
            end else if (nib == wmhp_pkg::CTL_EXTENSION && sz > wmhp_pkg::CNT_W'(1) &&
                         ext >= wmhp_pkg::EXT_MIN && ext <= wmhp_pkg::EXT_MAX) begin
               code = wmhp_pkg::SUB_EXT_BASE + {2'b00, ext};
            end else begin
               code = wmhp_pkg::SUB_UNKNOWN;
            end
         end
         default: code = wmhp_pkg::SUB_UNKNOWN;
      endcase

      is_ext  = (t == wmhp_pkg::TYPE_CTRL) && (code >= wmhp_pkg::SUB_EXT_BASE) &&
                (code != wmhp_pkg::SUB_UNKNOWN);
      flags   = is_ext ? {b1[7:4], 4'b0000} : b1;
      to_ds   = flags[0];
      from_ds = flags[1];

      q     = (to_ds && from_ds) ? ((sz > wmhp_pkg::CNT_W'(31)) ? fs.qos_long : 8'h00)
                                 : fs.qos_short;
      amsdu = (t == wmhp_pkg::TYPE_DATA) && (nib >= wmhp_pkg::DATA_QOS_FIRST) &&
              (nib != wmhp_pkg::DATA_RSVD) && (sz >= wmhp_pkg::CNT_W'(31)) && q[7];

      ctl_a2 = (t == wmhp_pkg::TYPE_CTRL) &&
               (code == {2'b00, wmhp_pkg::CTL_BAR} || code == {2'b00, wmhp_pkg::CTL_BA} ||
                code == {2'b00, wmhp_pkg::CTL_PSPOLL} || code == {2'b00, wmhp_pkg::CTL_RTS} ||
                code == {2'b00, wmhp_pkg::CTL_CFEND} ||
                code == {2'b00, wmhp_pkg::CTL_CFEND_ACK});
      a1 = (sz >= wmhp_pkg::CNT_W'(10)) ? wmhp_pkg::SLOT_1 : wmhp_pkg::SLOT_NONE;
      a2 = (sz >= wmhp_pkg::CNT_W'(16) && (t == wmhp_pkg::TYPE_MGMT ||
            t == wmhp_pkg::TYPE_DATA || ctl_a2)) ? wmhp_pkg::SLOT_2 : wmhp_pkg::SLOT_NONE;
      a3 = (sz >= wmhp_pkg::CNT_W'(22) && (t == wmhp_pkg::TYPE_MGMT ||
            t == wmhp_pkg::TYPE_DATA)) ? wmhp_pkg::SLOT_3 : wmhp_pkg::SLOT_NONE;
      a4 = (sz >= wmhp_pkg::CNT_W'(30) && t == wmhp_pkg::TYPE_DATA && to_ds && from_ds) ?
           wmhp_pkg::SLOT_4 : wmhp_pkg::SLOT_NONE;

      ra = (t == wmhp_pkg::TYPE_MGMT || t == wmhp_pkg::TYPE_DATA ||
            (t == wmhp_pkg::TYPE_CTRL && code != {2'b00, wmhp_pkg::CTL_WRAPPER})) ?
           a1 : wmhp_pkg::SLOT_NONE;
      bssid = wmhp_pkg::SLOT_NONE;
      da    = wmhp_pkg::SLOT_NONE;
      sa    = wmhp_pkg::SLOT_NONE;
      unique case (t)
         wmhp_pkg::TYPE_MGMT: begin
            bssid = a3;
            da    = a1;
            sa    = a2;
         end
         wmhp_pkg::TYPE_CTRL: begin
            if (code == {2'b00, wmhp_pkg::CTL_PSPOLL}) begin
               bssid = ra;
            end else if (code == {2'b00, wmhp_pkg::CTL_CFEND} ||
                         code == {2'b00, wmhp_pkg::CTL_CFEND_ACK}) begin
               bssid = a2;
            end
         end
         wmhp_pkg::TYPE_DATA: begin
            priority if (!from_ds && !to_ds) bssid = a3;
            else if (!from_ds && to_ds) bssid = a2;
            else if (from_ds && !to_ds) bssid = a1;
            else if (amsdu) bssid = a3;
            else bssid = wmhp_pkg::SLOT_NONE;
            if (!from_ds) begin
               da = a1;
               sa = a2;
            end else if (!amsdu) begin
               da = a3;
               sa = to_ds ? a4 : a3;
            end
         end
         default: ;
      endcase

      st = wmhp_pkg::ie_start(t, nib);
      res.ssid_offset = '0;
      res.ssid_length = '0;
      if (st != '0 && sz > wmhp_pkg::CNT_W'(37) && fs.ssid_found &&
          (fs.ssid_pos == st + wmhp_pkg::CNT_W'(2) || fs.ssid_pos < sz)) begin
         res.ssid_offset = fs.ssid_pos[11:0];
         res.ssid_length = (fs.ssid_pos < sz) ? fs.ssid_len : 8'h00;
      end

      res.frame_type    = t;
      res.subtype_code  = code;
      res.fc_flags      = flags;
      res.amsdu_present = amsdu;
      res.ra_slot       = ra;
      res.ta_slot       = a2;
      res.bssid_slot    = bssid;
      res.da_slot       = da;
      res.sa_slot       = sa;
   end

endmodule

// ===== rtl/wlan_mac_header_parser_top.sv =====
`timescale 1ns / 1ps
// wlan_mac_header_parser_top: input register, byte tracker, decoder, result register.
// Depends on wmhp_pkg, wmhp_ifs, wmhp_byte_track, wmhp_decode.

// Takes one frame byte per cycle, except in the stall below, with no gaps needed
// between frames. Each accepted byte lands in an input register and from there
// updates the per-frame state; the byte marked last also produces the parse result
// into the output register, which drives the result outputs. The output register lets
// input continue while a result waits; input stalls only when a last byte arrives and
// the previous result has not yet been taken.
module wlan_mac_header_parser_top (
   input logic      clock,
   input logic      reset,
   wmhp_req_if.sink   req_bus,
   wmhp_rsp_if.source rsp_bus
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff, in_byte_in;
   logic                 in_last_ff, in_last_in;
   logic                 advance;
   logic                 out_valid_ff, out_valid_in;
   wmhp_pkg::result_type out_ff, out_in, res;
   wmhp_pkg::frame_state_type state_upd;

   assign advance = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   wmhp_byte_track u_track (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .frame_byte (in_byte_ff),
      .last_byte  (in_last_ff),
      .state_upd  (state_upd)
   );

   wmhp_decode u_decode (
      .fs  (state_upd),
      .res (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
         in_byte_in  = req_bus.frame_byte;
         in_last_in  = req_bus.last_byte;
      end
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance && in_last_ff) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      out_ff     <= out_in;
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.frame_type    = out_ff.frame_type;
   assign rsp_bus.subtype_code  = out_ff.subtype_code;
   assign rsp_bus.fc_flags      = out_ff.fc_flags;
   assign rsp_bus.amsdu_present = out_ff.amsdu_present;
   assign rsp_bus.ra_slot       = out_ff.ra_slot;
   assign rsp_bus.ta_slot       = out_ff.ta_slot;
   assign rsp_bus.bssid_slot    = out_ff.bssid_slot;
   assign rsp_bus.da_slot       = out_ff.da_slot;
   assign rsp_bus.sa_slot       = out_ff.sa_slot;
   assign rsp_bus.ssid_offset   = out_ff.ssid_offset;
   assign rsp_bus.ssid_length   = out_ff.ssid_length;

endmodule
